// ===== rtl/rrss_pkg.sv =====
// ----------------------------------------------------------------------------
// rrss_pkg
// shared widths, codes and interface structs of the round-robin slice
// scheduler
// ----------------------------------------------------------------------------
package rrss_pkg;

    localparam int SLOTS_DEF  = 8;

    localparam int ACT_W      = 2;
    localparam int SLOT_FW    = 3;
    localparam int BURST_W    = 16;
    localparam int ARRIVAL_W  = 16;
    localparam int TIME_W     = 32;
    localparam int QUANTUM_W  = 8;
    localparam int START_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input word actions
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd3;
    localparam logic [START_W-1:0]   START_RST   = 16'd1;
    localparam logic [TIME_W-1:0]    TIME_MAX    = 32'hFFFF_FFFF;

    // write into the slot table (index travels beside it)
    typedef struct packed {
        logic               en;
        logic               done;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  ready;
    } t_slot_wr;

    // outcome of one scan over the slot table
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  ready;
    } t_scan_res;

endpackage

// ===== rtl/round_robin_slice_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_core
// load and restart words are taken while idle; a step word blocks the next
// accept through the slot scan, which reads one memory entry per cycle,
// and the write back, which waits until the result register is free;
// the result register is loaded at write back
// synchronous active-low reset: all slots done, time = 1, totals zero,
// quantum 3, start time 1; slot burst and ready memory is not cleared
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_core #(
    parameter int  SLOTS  = rrss_pkg::SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // input words
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rrss_pkg::ACT_W-1:0]          i_action,
    input  logic [rrss_pkg::SLOT_FW-1:0]        i_slot,
    input  logic [rrss_pkg::BURST_W-1:0]        i_burst,
    input  logic [rrss_pkg::ARRIVAL_W-1:0]      i_arrival,

    // result words
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rrss_pkg::SLOT_FW-1:0]        o_chosen_slot,
    output logic [rrss_pkg::TIME_W-1:0]         o_slice_start,
    output logic [rrss_pkg::TIME_W-1:0]         o_slice_end,
    output logic                                o_finished,
    output logic                                o_idle,
    output logic                                o_all_done,
    output logic [rrss_pkg::TIME_W-1:0]         o_total_wait,
    output logic [rrss_pkg::TIME_W-1:0]         o_total_busy,

    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rrss_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int TW = rrss_pkg::TIME_W;
    localparam int BW = rrss_pkg::BURST_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    // saturating add of two time values
    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? rrss_pkg::TIME_MAX : s[TW-1:0];
    endfunction

    t_state                          r_state, n_state;
    logic [rrss_pkg::QUANTUM_W-1:0]  r_quantum;
    logic [rrss_pkg::START_W-1:0]    r_start;
    logic [TW-1:0]                   r_time;
    logic [TW-1:0]                   r_wait;
    logic [TW-1:0]                   r_busy_sum;
    logic                            r_o_valid;

    logic [rrss_pkg::SLOT_FW-1:0]    r_o_slot;
    logic [TW-1:0]                   r_o_start;
    logic [TW-1:0]                   r_o_end;
    logic                            r_o_fin;
    logic                            r_o_idle;
    logic                            r_o_all;
    logic [TW-1:0]                   r_o_wait;
    logic [TW-1:0]                   r_o_busy;

    rrss_pkg::t_slot_wr              tbl_wr;
    logic [SLOT_W-1:0]               tbl_wr_idx;
    rrss_pkg::t_scan_res             scan_res;
    logic [SLOT_W-1:0]               scan_pick;
    logic [SLOTS-1:0]                done_vec;

    logic                            in_fire;
    logic                            load_ok;
    logic                            scan_start;
    logic                            upd_fire;
    logic [BW-1:0]                   q_ext;
    logic                            fin;
    logic [BW-1:0]                   len;
    logic [TW-1:0]                   upd_time;
    logic [TW-1:0]                   upd_wait;
    logic [TW-1:0]                   upd_busy;
    logic [SLOTS-1:0]                done_after;

    assign o_ready    = (r_state == S_IDLE);
    assign in_fire    = i_valid && o_ready;
    // loads beyond the table are dropped
    assign load_ok    = ((SLOT_W + 3)'(i_slot) < (SLOT_W + 3)'(SLOTS));
    assign scan_start = in_fire && (i_action == rrss_pkg::ACT_STEP);
    // write back only once the result register is free
    assign upd_fire   = (r_state == S_UPDATE) && (!r_o_valid || i_ready);

    rrss_slot_table #(
        .SLOTS      (SLOTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_cur_time (r_time),
        .i_wr       (tbl_wr),
        .i_wr_idx   (tbl_wr_idx),
        .o_res      (scan_res),
        .o_pick     (scan_pick),
        .o_done     (done_vec)
    );

    // slice arithmetic on the scan outcome
    always_comb begin
        q_ext    = BW'(r_quantum);
        fin      = (scan_res.burst <= q_ext);
        if (!scan_res.found) begin
            len = BW'(1);           // idle tick
        end else if (fin) begin
            len = scan_res.burst;
        end else begin
            len = q_ext;
        end
        upd_time = sat_add(r_time, TW'(len));
        // ready time never exceeds current time, so no wrap here
        upd_wait = sat_add(r_wait, r_time - scan_res.ready);
        upd_busy = sat_add(r_busy_sum, TW'(len));
        done_after = done_vec;
        if (scan_res.found && fin) begin
            done_after = done_vec | (SLOTS'(1) << scan_pick);
        end
    end

    // single table write port: load in idle, write back after a scan
    always_comb begin
        tbl_wr     = '0;
        tbl_wr_idx = SLOT_W'(i_slot);
        if (upd_fire) begin
            tbl_wr_idx   = scan_pick;
            tbl_wr.en    = scan_res.found;
            tbl_wr.done  = fin;
            tbl_wr.burst = fin ? '0 : (scan_res.burst - q_ext);
            tbl_wr.ready = fin ? scan_res.ready : upd_time;
        end else if (in_fire && (i_action == rrss_pkg::ACT_LOAD)) begin
            tbl_wr.en    = load_ok;
            tbl_wr.done  = 1'b0;
            tbl_wr.burst = i_burst;
            tbl_wr.ready = TW'(i_arrival);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (scan_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_res.valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (upd_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_quantum  <= rrss_pkg::QUANTUM_RST;
            r_start    <= rrss_pkg::START_RST;
            r_time     <= TW'(rrss_pkg::START_RST);
            r_wait     <= '0;
            r_busy_sum <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrss_pkg::CFG_QUANTUM: r_quantum <= i_cfg_wdata[rrss_pkg::QUANTUM_W-1:0];
                    rrss_pkg::CFG_START:   r_start   <= i_cfg_wdata[rrss_pkg::START_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire && (i_action == rrss_pkg::ACT_RESTART)) begin
                r_time     <= TW'(r_start);
                r_wait     <= '0;
                r_busy_sum <= '0;
            end

            if (upd_fire) begin
                r_time <= upd_time;
                if (scan_res.found) begin
                    r_wait     <= upd_wait;
                    r_busy_sum <= upd_busy;
                end
            end

            if (upd_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_o_start <= r_time;
            r_o_end   <= upd_time;
            r_o_idle  <= !scan_res.found;
            r_o_all   <= &done_after;
            if (scan_res.found) begin
                r_o_slot <= rrss_pkg::SLOT_FW'(scan_pick);
                r_o_fin  <= fin;
                r_o_wait <= upd_wait;
                r_o_busy <= upd_busy;
            end else begin
                r_o_slot <= '0;
                r_o_fin  <= 1'b0;
                r_o_wait <= r_wait;
                r_o_busy <= r_busy_sum;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_chosen_slot = r_o_slot;
    assign o_slice_start = r_o_start;
    assign o_slice_end   = r_o_end;
    assign o_finished    = r_o_fin;
    assign o_idle        = r_o_idle;
    assign o_all_done    = r_o_all;
    assign o_total_wait  = r_o_wait;
    assign o_total_busy  = r_o_busy;

    // the table must not change under a running scan
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !tbl_wr.en)
        else $error("slot table written during scan");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.valid |-> (r_state == S_SCAN))
        else $error("scan finished outside scan state");

    a_idle_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle) |-> !o_finished)
        else $error("idle slice marked finished");

    a_end_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slice_end >= o_slice_start))
        else $error("slice ends before it starts");

    a_update_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> ((r_state == S_IDLE) && r_o_valid))
        else $error("write back did not present a result");

endmodule

// ===== rtl/rrss_slot_table.sv =====
// ----------------------------------------------------------------------------
// rrss_slot_table
// slot memory with done flags and a one-entry-per-cycle scan for the
// earliest ready unfinished process
// ----------------------------------------------------------------------------
module rrss_slot_table #(
    parameter int  SLOTS  = rrss_pkg::SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int CNT_W  = $clog2(SLOTS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rrss_pkg::TIME_W-1:0]       i_cur_time,
    input  rrss_pkg::t_slot_wr                i_wr,
    input  logic [SLOT_W-1:0]                 i_wr_idx,
    output rrss_pkg::t_scan_res               o_res,
    output logic [SLOT_W-1:0]                 o_pick,
    output logic [SLOTS-1:0]                  o_done
);

    localparam int ENT_W = rrss_pkg::BURST_W + rrss_pkg::TIME_W;

    logic [ENT_W-1:0]              r_mem [SLOTS];
    logic [ENT_W-1:0]              r_rd_data;
    logic [SLOTS-1:0]              r_done;
    logic                          r_busy;
    logic                          r_fin;
    logic                          r_found;
    logic [CNT_W-1:0]              r_cnt;
    logic [rrss_pkg::TIME_W-1:0]   r_best;
    logic [rrss_pkg::BURST_W-1:0]  r_burst;
    logic [SLOT_W-1:0]             r_pick;

    logic [CNT_W-1:0]              cnt_m1;
    logic [SLOT_W-1:0]             cmp_idx;
    logic [rrss_pkg::BURST_W-1:0]  rd_burst;
    logic [rrss_pkg::TIME_W-1:0]   rd_ready;
    logic                          cnt_last;
    logic                          take;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_idx] <= {i_wr.burst, i_wr.ready};
        end
        if (r_busy && (r_cnt < CNT_W'(SLOTS))) begin
            r_rd_data <= r_mem[r_cnt[SLOT_W-1:0]];
        end
    end

    // read data is registered, so it belongs to the entry before the address counter
    always_comb begin
        cnt_m1   = r_cnt - CNT_W'(1);
        cmp_idx  = cnt_m1[SLOT_W-1:0];
        rd_burst = r_rd_data[ENT_W-1:rrss_pkg::TIME_W];
        rd_ready = r_rd_data[rrss_pkg::TIME_W-1:0];
        cnt_last = (r_cnt == CNT_W'(SLOTS));
        // ties go to the later slot, hence <= against the best so far
        take     = r_busy && (r_cnt != '0) && !r_done[cmp_idx] &&
                   (rd_ready <= i_cur_time) && (!r_found || (rd_ready <= r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_found <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                if (take) begin
                    r_found <= 1'b1;
                end
                if (cnt_last) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best  <= rd_ready;
            r_burst <= rd_burst;
            r_pick  <= cmp_idx;
        end
    end

    // done flags, all set at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '1;
        end else if (i_wr.en) begin
            r_done[i_wr_idx] <= i_wr.done;
        end
    end

    assign o_res.valid = r_fin;
    assign o_res.found = r_found;
    assign o_res.burst = r_burst;
    assign o_res.ready = r_best;
    assign o_pick      = r_pick;
    assign o_done      = r_done;

endmodule

// ===== verif/round_robin_slice_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_core_tb
// self-checking bench for the round-robin slice scheduler: a behavioral
// scheduler in the bench follows every accepted input word and queues the
// slice it should produce; a monitor compares each result word field by
// field; directed words cover ties, zero bursts, idle steps, ignored words
// and register extremes, then random episodes of restart, load and step
// words run under random stalls on both handshakes
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_core_tb;

    localparam int NUM_SLOTS    = rrss_pkg::SLOTS_DEF;
    localparam int SETTLE       = NUM_SLOTS + 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 1350;

    localparam int ACT_W      = rrss_pkg::ACT_W;
    localparam int SLOT_FW    = rrss_pkg::SLOT_FW;
    localparam int BURST_W    = rrss_pkg::BURST_W;
    localparam int ARRIVAL_W  = rrss_pkg::ARRIVAL_W;
    localparam int TIME_W     = rrss_pkg::TIME_W;
    localparam int QUANTUM_W  = rrss_pkg::QUANTUM_W;
    localparam int START_W    = rrss_pkg::START_W;
    localparam int CFG_IDX_W  = rrss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rrss_pkg::CFG_DATA_W;

    // codes the package leaves unnamed
    localparam logic [ACT_W-1:0]     ACT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // one predicted result word
    typedef struct packed {
        logic [SLOT_FW-1:0] slot;
        logic [TIME_W-1:0]  start_t;
        logic [TIME_W-1:0]  end_t;
        logic               finished;
        logic               idle;
        logic               all_done;
        logic [TIME_W-1:0]  wait_total;
        logic [TIME_W-1:0]  busy_total;
    } t_slice_rec;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [ACT_W-1:0]      in_action = rrss_pkg::ACT_LOAD;
    logic [SLOT_FW-1:0]    in_slot   = '0;
    logic [BURST_W-1:0]    in_burst  = '0;
    logic [ARRIVAL_W-1:0]  in_arrival = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SLOT_FW-1:0]    out_slot;
    logic [TIME_W-1:0]     out_start;
    logic [TIME_W-1:0]     out_end;
    logic                  out_finished;
    logic                  out_idle;
    logic                  out_all_done;
    logic [TIME_W-1:0]     out_wait;
    logic [TIME_W-1:0]     out_busy;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = rrss_pkg::CFG_QUANTUM;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // scheduler state as the bench sees it
    logic [BURST_W-1:0]    sched_burst [NUM_SLOTS];
    logic [TIME_W-1:0]     sched_ready [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  sched_done;
    logic [TIME_W-1:0]     sched_now;
    logic [TIME_W-1:0]     sched_wait;
    logic [TIME_W-1:0]     sched_busy;
    logic [QUANTUM_W-1:0]  sched_quantum;
    logic [START_W-1:0]    sched_start;

    t_slice_rec            pending_slices [$];
    t_slice_rec            want_slice;
    int unsigned           mismatches  = 0;
    int unsigned           cycle_count = 0;
    int unsigned           words_sent  = 0;
    bit                    calm        = 1'b0;   // no stalls on either side

    round_robin_slice_scheduler_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_action      (in_action),
        .i_slot        (in_slot),
        .i_burst       (in_burst),
        .i_arrival     (in_arrival),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_chosen_slot (out_slot),
        .o_slice_start (out_start),
        .o_slice_end   (out_end),
        .o_finished    (out_finished),
        .o_idle        (out_idle),
        .o_all_done    (out_all_done),
        .o_total_wait  (out_wait),
        .o_total_busy  (out_busy),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side stalls in about one cycle of eight, none during calm stretches
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 12);
    end

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? rrss_pkg::TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // advance the bench scheduler by one accepted input word
    task automatic predict_slice(input logic [ACT_W-1:0]     act,
                                 input logic [SLOT_FW-1:0]   slot,
                                 input logic [BURST_W-1:0]   burst,
                                 input logic [ARRIVAL_W-1:0] arrival);
        t_slice_rec        rec;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] len;
        logic [TIME_W-1:0] ready_at;
        logic              found;
        int                pick;
        rec   = '0;
        best  = '0;
        found = 1'b0;
        pick  = 0;
        case (act)
            rrss_pkg::ACT_LOAD: begin
                sched_burst[slot] = burst;
                sched_ready[slot] = TIME_W'(arrival);
                sched_done[slot]  = 1'b0;
            end
            rrss_pkg::ACT_RESTART: begin
                sched_now  = TIME_W'(sched_start);
                sched_wait = '0;
                sched_busy = '0;
            end
            rrss_pkg::ACT_STEP: begin
                // earliest ready unfinished slot; later slots win ties
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!sched_done[i] && sched_ready[i] <= sched_now &&
                        (!found || sched_ready[i] <= best)) begin
                        found = 1'b1;
                        best  = sched_ready[i];
                        pick  = i;
                    end
                end
                rec.start_t = sched_now;
                if (!found) begin
                    // nothing ready: one tick passes, totals hold
                    sched_now = sat_add(sched_now, TIME_W'(1));
                    rec.idle  = 1'b1;
                end else begin
                    ready_at = sched_ready[pick];
                    if (sched_burst[pick] <= sched_quantum) begin
                        len               = TIME_W'(sched_burst[pick]);
                        sched_burst[pick] = '0;
                        sched_done[pick]  = 1'b1;
                        rec.finished      = 1'b1;
                        sched_now         = sat_add(sched_now, len);
                    end else begin
                        len               = TIME_W'(sched_quantum);
                        sched_burst[pick] = sched_burst[pick] - BURST_W'(sched_quantum);
                        sched_now         = sat_add(sched_now, len);
                        sched_ready[pick] = sched_now;
                    end
                    sched_wait = sat_add(sched_wait, rec.start_t - ready_at);
                    sched_busy = sat_add(sched_busy, len);
                    rec.slot   = SLOT_FW'(pick);
                end
                rec.end_t      = sched_now;
                rec.all_done   = &sched_done;
                rec.wait_total = sched_wait;
                rec.busy_total = sched_busy;
                pending_slices.push_back(rec);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_slices.size() == 0) begin
                $error("result word with no step word pending");
                mismatches++;
            end else begin
                want_slice = pending_slices.pop_front();
                check_field("chosen_slot", TIME_W'(want_slice.slot), TIME_W'(out_slot));
                check_field("slice_start", want_slice.start_t, out_start);
                check_field("slice_end", want_slice.end_t, out_end);
                check_field("finished", TIME_W'(want_slice.finished), TIME_W'(out_finished));
                check_field("idle", TIME_W'(want_slice.idle), TIME_W'(out_idle));
                check_field("all_done", TIME_W'(want_slice.all_done), TIME_W'(out_all_done));
                check_field("total_wait", want_slice.wait_total, out_wait);
                check_field("total_busy", want_slice.busy_total, out_busy);
            end
        end
    end

    // present one word, with an occasional gap ahead of it, and hold it until taken
    task automatic send_word(input logic [ACT_W-1:0]     act,
                             input logic [SLOT_FW-1:0]   slot,
                             input logic [BURST_W-1:0]   burst,
                             input logic [ARRIVAL_W-1:0] arrival);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 12)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_action  <= act;
        in_slot    <= slot;
        in_burst   <= burst;
        in_arrival <= arrival;
        do @(posedge clk); while (in_ready !== 1'b1);
        predict_slice(act, slot, burst, arrival);
        if (act != ACT_SPARE)
            words_sent++;
    endtask

    // random slot, burst and arrival fields
    function automatic logic [SLOT_FW-1:0] random_slot();
        return SLOT_FW'($urandom_range(NUM_SLOTS - 1));
    endfunction

    function automatic logic [BURST_W-1:0] random_field();
        return BURST_W'($urandom_range(16'hFFFF));
    endfunction

    // step word with random filler in the unused fields
    task automatic send_step();
        send_word(rrss_pkg::ACT_STEP, random_slot(), random_field(),
                  ARRIVAL_W'(random_field()));
    endtask

    // stop sending, let every result come home and the block go quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_slices.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            rrss_pkg::CFG_QUANTUM: sched_quantum = data[QUANTUM_W-1:0];
            rrss_pkg::CFG_START:   sched_start   = data[START_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // arrival close to the current time, mostly already ready
    function automatic logic [ARRIVAL_W-1:0] arrival_near_now();
        longint t;
        t = longint'(sched_now);
        if ($urandom_range(99) < 70)
            t = t - longint'($urandom_range(0, 30));
        else
            t = t + longint'($urandom_range(1, 8));
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return ARRIVAL_W'(t);
    endfunction

    // mostly a few slices long, sometimes anything
    function automatic logic [BURST_W-1:0] random_burst();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return BURST_W'($urandom_range(0, int'(sched_quantum) * 3));
        else if (roll < 88)
            return BURST_W'($urandom_range(0, 15));
        else
            return BURST_W'($urandom_range(16'hFFFF));
    endfunction

    // nothing loaded: idle step, ignored word, zero burst completes at once
    task automatic test_idle_and_ignored();
        send_step();
        send_word(ACT_SPARE, 3'd7, 16'hFFFF, 16'hFFFF);
        send_word(rrss_pkg::ACT_LOAD, 3'd7, 16'h0000, 16'h0000);
        send_step();
        drain_results();
    endtask

    // equal ready times pick the higher slot, quantum split, far-off arrival
    task automatic test_ties_and_slices();
        send_word(rrss_pkg::ACT_LOAD, 3'd0, 16'hFFFF, 16'hFFFF);
        send_word(rrss_pkg::ACT_LOAD, 3'd5, 16'd5, 16'd2);
        send_word(rrss_pkg::ACT_LOAD, 3'd2, 16'd2, 16'd2);
        repeat (4) send_step();
        send_word(rrss_pkg::ACT_RESTART, 3'd0, 16'd0, 16'd0);
        drain_results();
    endtask

    // register extremes, spare indexes, quantum zero and masked upper bits
    task automatic test_config_extremes();
        write_reg(rrss_pkg::CFG_QUANTUM, 16'd255);
        write_reg(rrss_pkg::CFG_START, 16'hFFFF);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'hFFFF);
        send_word(rrss_pkg::ACT_RESTART, 3'd0, 16'd0, 16'd0);
        send_step();
        send_word(rrss_pkg::ACT_LOAD, 3'd0, 16'd1, 16'd0);
        send_step();
        drain_results();
        write_reg(rrss_pkg::CFG_QUANTUM, 16'hFF00);
        write_reg(rrss_pkg::CFG_START, 16'd0);
        send_word(rrss_pkg::ACT_RESTART, 3'd0, 16'd0, 16'd0);
        send_word(rrss_pkg::ACT_LOAD, 3'd3, 16'd4, 16'd0);
        send_step();
        send_step();
        send_word(rrss_pkg::ACT_LOAD, 3'd3, 16'd0, 16'd0);
        send_step();
        drain_results();
        write_reg(rrss_pkg::CFG_QUANTUM, 16'h5A01);
    endtask

    // restart, refresh live slots, random mix, often run until all done
    task automatic test_random_episodes();
        int episode;
        int span;
        int roll;
        int steps;
        episode    = 0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            calm = (episode >= 8 && episode < 16);
            if (episode % 3 == 0) begin
                drain_results();
                case ($urandom_range(3))
                    0:       write_reg(rrss_pkg::CFG_QUANTUM, 16'd1);
                    1:       write_reg(rrss_pkg::CFG_QUANTUM, 16'd255);
                    2:       write_reg(rrss_pkg::CFG_QUANTUM,
                                       CFG_DATA_W'($urandom_range(1, 8)));
                    default: write_reg(rrss_pkg::CFG_QUANTUM,
                                       CFG_DATA_W'($urandom_range(1, 255)));
                endcase
                case ($urandom_range(3))
                    0:       write_reg(rrss_pkg::CFG_START, 16'd0);
                    1:       write_reg(rrss_pkg::CFG_START, 16'hFFFF);
                    2:       write_reg(rrss_pkg::CFG_START,
                                       CFG_DATA_W'($urandom_range(0, 200)));
                    default: write_reg(rrss_pkg::CFG_START,
                                       CFG_DATA_W'($urandom_range(16'hFFFF)));
                endcase
            end
            send_word(rrss_pkg::ACT_RESTART, random_slot(), random_field(),
                      ARRIVAL_W'(random_field()));
            // live slots get a ready time on the new time base
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!sched_done[i] || $urandom_range(1))
                    send_word(rrss_pkg::ACT_LOAD, SLOT_FW'(i), random_burst(),
                              arrival_near_now());
            end
            span = $urandom_range(10, 40);
            repeat (span) begin
                roll = $urandom_range(99);
                if (roll < 62)
                    send_step();
                else if (roll < 90)
                    send_word(rrss_pkg::ACT_LOAD, random_slot(), random_burst(),
                              arrival_near_now());
                else if (roll < 93)
                    send_word(rrss_pkg::ACT_RESTART, random_slot(), random_field(),
                              ARRIVAL_W'(random_field()));
                else
                    send_word(ACT_SPARE, random_slot(), random_field(),
                              ARRIVAL_W'(random_field()));
            end
            if ($urandom_range(1)) begin
                steps = 0;
                while (sched_done != '1 && steps < 48) begin
                    send_step();
                    steps++;
                end
                // one more: idle if everything is done
                send_step();
            end
            episode++;
        end
        calm = 1'b0;
        drain_results();
    endtask

    initial begin
        // bench scheduler starts from the reset state
        sched_quantum = rrss_pkg::QUANTUM_RST;
        sched_start   = rrss_pkg::START_RST;
        sched_now     = TIME_W'(rrss_pkg::START_RST);
        sched_wait    = '0;
        sched_busy    = '0;
        sched_done    = '1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sched_burst[i] = '0;
            sched_ready[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_ignored();
        test_ties_and_slices();
        test_config_extremes();
        test_random_episodes();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
